[design/qsgm_pkg.sv]
// shared types, register codes and arithmetic helpers of the quad-to-stereo gain mixer
// used by every module of the mixer; depends on nothing
package qsgm_pkg;

  localparam int unsigned FifoDepthDef = 2;
  localparam int unsigned AddrW        = 5;
  localparam int unsigned DataW        = 32;

  localparam logic signed [15:0] S16Min = 16'sh8000;
  localparam logic signed [15:0] S16Max = 16'sh7fff;

  typedef enum logic [2:0] {
    RegAux1   = 3'd0,
    RegAux2   = 3'd1,
    RegGain0  = 3'd2,
    RegGain1  = 3'd3,
    RegGain2  = 3'd4,
    RegFormat = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    FmtMono     = 2'd0,
    FmtStereo   = 2'd1,
    FmtSurround = 2'd2
  } fmt_e;

  typedef enum logic [1:0] {
    Mix0    = 2'd0,
    Mix1    = 2'd1,
    Mix2    = 2'd2,
    MixNone = 2'd3
  } mix_e;

  typedef struct packed {
    logic        aux1;
    logic        aux2;
    logic [15:0] gain0;
    logic [15:0] gain1;
    logic [15:0] gain2;
    logic [1:0]  fmt;
  } cfg_t;

  // one classified sample as it waits for the datapath
  typedef struct packed {
    logic             skip;
    mix_e             mix;
    logic             aux;
    logic             mono;
    logic [15:0]      gain;
    logic [3:0][31:0] samp;
    logic [3:0][31:0] send;
  } item_t;

  // divide by 2^15 (mono) or 2^14 (stereo) toward zero, then clamp to 16 bits
  function automatic logic signed [15:0] div_sat(input logic signed [50:0] v,
                                                 input logic mono);
    logic signed [50:0] q;
    logic               rem;
    q   = mono ? (v >>> 15) : (v >>> 14);
    rem = mono ? (|v[14:0]) : (|v[13:0]);
    if (v[50] && rem) begin
      q = q + 51'sd1;
    end
    if (q[50] && !(&q[50:15])) begin
      return S16Min;
    end else if (!q[50] && (|q[50:15])) begin
      return S16Max;
    end
    return q[15:0];
  endfunction

  // saturating 16-bit add
  function automatic logic signed [15:0] sat_add16(input logic signed [15:0] a,
                                                   input logic signed [15:0] b);
    logic signed [16:0] s;
    s = {a[15], a} + {b[15], b};
    if (s[16] != s[15]) begin
      return s[16] ? S16Min : S16Max;
    end
    return s[15:0];
  endfunction

endpackage

[design/qsgm_regs.sv]
// apb configuration registers of the mixer
// depends on qsgm_pkg for register codes and the config struct
module qsgm_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [qsgm_pkg::AddrW-1:0] paddr,
  input  logic [qsgm_pkg::DataW-1:0] pwdata,
  output logic [qsgm_pkg::DataW-1:0] prdata,
  output logic                       pready,
  output qsgm_pkg::cfg_t             cfg_o
);

  qsgm_pkg::cfg_t   cfg_q, cfg_d;
  logic             wr_en;
  logic [2:0]       idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (qsgm_pkg::reg_idx_e'(idx))
        qsgm_pkg::RegAux1:   cfg_d.aux1  = pwdata[0];
        qsgm_pkg::RegAux2:   cfg_d.aux2  = pwdata[0];
        qsgm_pkg::RegGain0:  cfg_d.gain0 = pwdata[15:0];
        qsgm_pkg::RegGain1:  cfg_d.gain1 = pwdata[15:0];
        qsgm_pkg::RegGain2:  cfg_d.gain2 = pwdata[15:0];
        qsgm_pkg::RegFormat: cfg_d.fmt   = pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (qsgm_pkg::reg_idx_e'(idx))
      qsgm_pkg::RegAux1:   prdata = {31'd0, cfg_q.aux1};
      qsgm_pkg::RegAux2:   prdata = {31'd0, cfg_q.aux2};
      qsgm_pkg::RegGain0:  prdata = {16'd0, cfg_q.gain0};
      qsgm_pkg::RegGain1:  prdata = {16'd0, cfg_q.gain1};
      qsgm_pkg::RegGain2:  prdata = {16'd0, cfg_q.gain2};
      qsgm_pkg::RegFormat: prdata = {30'd0, cfg_q.fmt};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[design/qsgm_front.sv]
// front end: accepts a quad sample, picks aux return or input, selects gain
// depends on qsgm_pkg for the item and config structs
module qsgm_front (
  input  logic                  valid_i,
  output logic                  stall_o,
  input  logic [1:0]            mix_index_i,
  input  logic [3:0][31:0]      in_ch_i,
  input  logic [3:0][31:0]      ret_ch_i,
  input  qsgm_pkg::cfg_t        cfg_i,
  input  logic                  full_i,
  output logic                  push_o,
  output qsgm_pkg::item_t       item_o
);

  qsgm_pkg::mix_e mix;
  logic           aux;

  assign mix     = qsgm_pkg::mix_e'(mix_index_i);
  assign stall_o = full_i;
  assign push_o  = valid_i && !full_i;

  assign aux = ((mix == qsgm_pkg::Mix1) && cfg_i.aux1) ||
               ((mix == qsgm_pkg::Mix2) && cfg_i.aux2);

  always_comb begin
    item_o.skip = (mix == qsgm_pkg::MixNone);
    item_o.mix  = mix;
    item_o.aux  = aux;
    item_o.mono = (cfg_i.fmt == qsgm_pkg::FmtMono);
    item_o.samp = aux ? ret_ch_i : in_ch_i;
    item_o.send = aux ? in_ch_i : '0;
    case (mix)
      qsgm_pkg::Mix0: item_o.gain = cfg_i.gain0;
      qsgm_pkg::Mix1: item_o.gain = cfg_i.gain1;
      qsgm_pkg::Mix2: item_o.gain = cfg_i.gain2;
      default:        item_o.gain = '0;
    endcase
  end

endmodule

[design/qsgm_fifo.sv]
// short queue of classified samples between front end and datapath
// depends on qsgm_pkg for the item struct
module qsgm_fifo #(
  parameter int unsigned Depth = qsgm_pkg::FifoDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  qsgm_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output qsgm_pkg::item_t item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  qsgm_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

[design/qsgm_back.sv]
// datapath: gain multiply, downmix, truncate and clamp, accumulate, output register
// depends on qsgm_pkg for the item struct and arithmetic helpers
module qsgm_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  qsgm_pkg::item_t  item_i,
  output logic             pop_o,
  output logic             valid_o,
  input  logic             stall_i,
  output logic [3:0][31:0] send_ch_o,
  output logic             send_valid_o,
  output logic [15:0]      out_left_o,
  output logic [15:0]      out_right_o,
  output logic             out_valid_o
);

  typedef struct packed {
    logic             skip;
    qsgm_pkg::mix_e   mix;
    logic             aux;
    logic             mono;
    logic [3:0][31:0] send;
  } ctl_t;

  logic                     en;
  logic [3:0]               vld_q;
  ctl_t                     c1_q, c2_q, c3_q;
  logic signed [48:0]       prod_q [4];
  logic signed [49:0]       pl_q, pr_q;
  logic signed [15:0]       l_q, r_q;
  logic signed [50:0]       vl, vr;
  logic signed [15:0]       acc_l_q, acc_r_q, acc_l_d, acc_r_d;
  logic                     upd;

  // whole pipe advances unless the output register is held
  assign en      = !vld_q[3] || !stall_i;
  assign pop_o   = en && !empty_i;
  assign valid_o = vld_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[2:0], !empty_i};
    end
  end

  // stage 1: four gain products
  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_q <= '{skip: item_i.skip, mix: item_i.mix, aux: item_i.aux,
                mono: item_i.mono, send: item_i.send};
      for (int i = 0; i < 4; i++) begin
        prod_q[i] <= $signed({1'b0, item_i.gain}) * $signed(item_i.samp[i]);
      end
    end
  end

  // stage 2: left and right pair sums
  always_ff @(posedge clk_i) begin
    if (en) begin
      c2_q <= c1_q;
      pl_q <= {prod_q[0][48], prod_q[0]} + {prod_q[2][48], prod_q[2]};
      pr_q <= {prod_q[1][48], prod_q[1]} + {prod_q[3][48], prod_q[3]};
    end
  end

  // stage 3: downmix, divide toward zero, clamp
  assign vl = c2_q.mono ? ({pl_q[49], pl_q} + {pr_q[49], pr_q}) : {pl_q[49], pl_q};
  assign vr = {pr_q[49], pr_q};

  always_ff @(posedge clk_i) begin
    if (en) begin
      c3_q <= c2_q;
      l_q  <= qsgm_pkg::div_sat(vl, c2_q.mono);
      r_q  <= c2_q.mono ? qsgm_pkg::div_sat(vl, 1'b1) : qsgm_pkg::div_sat(vr, 1'b0);
    end
  end

  // stage 4: accumulate, mix 0 starts from zero
  assign upd     = en && vld_q[2] && !c3_q.skip;
  assign acc_l_d = qsgm_pkg::sat_add16((c3_q.mix == qsgm_pkg::Mix0) ? 16'sd0 : acc_l_q, l_q);
  assign acc_r_d = qsgm_pkg::sat_add16((c3_q.mix == qsgm_pkg::Mix0) ? 16'sd0 : acc_r_q, r_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_l_q <= '0;
      acc_r_q <= '0;
    end else if (upd) begin
      acc_l_q <= acc_l_d;
      acc_r_q <= acc_r_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (c3_q.skip) begin
        send_ch_o    <= '0;
        send_valid_o <= 1'b0;
        out_left_o   <= '0;
        out_right_o  <= '0;
        out_valid_o  <= 1'b0;
      end else begin
        send_ch_o    <= c3_q.send;
        send_valid_o <= c3_q.aux;
        out_valid_o  <= (c3_q.mix == qsgm_pkg::Mix2);
        out_left_o   <= (c3_q.mix == qsgm_pkg::Mix2) ? acc_l_d : '0;
        out_right_o  <= (c3_q.mix == qsgm_pkg::Mix2) ? acc_r_d : '0;
      end
    end
  end

endmodule

[design/quad_to_stereo_gain_mixer_core.sv]
// quad-to-stereo gain mixer: from input acceptance to result valid a sample passes through
// (queue write at the accepting edge, then multiply, pair sum, divide/clamp, accumulate stages)
// throughput one sample per cycle while stall_i does not hold the output; the accumulate stage closes its own loop
// reset (rst_ni, async low) clears config registers, accumulators, queue and pipeline valid flags
// depends on qsgm_pkg, qsgm_regs, qsgm_front, qsgm_fifo, qsgm_back
module quad_to_stereo_gain_mixer_core #(
  parameter int unsigned FifoDepth = qsgm_pkg::FifoDepthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // apb configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [qsgm_pkg::AddrW-1:0] paddr,
  input  logic [qsgm_pkg::DataW-1:0] pwdata,
  output logic [qsgm_pkg::DataW-1:0] prdata,
  output logic                       pready,
  // input channel
  input  logic                       valid_i,
  output logic                       stall_o,
  input  logic [1:0]                 mix_index_i,
  input  logic signed [31:0]         in_ch0_i,
  input  logic signed [31:0]         in_ch1_i,
  input  logic signed [31:0]         in_ch2_i,
  input  logic signed [31:0]         in_ch3_i,
  input  logic signed [31:0]         ret_ch0_i,
  input  logic signed [31:0]         ret_ch1_i,
  input  logic signed [31:0]         ret_ch2_i,
  input  logic signed [31:0]         ret_ch3_i,
  // result channel
  output logic                       valid_o,
  input  logic                       stall_i,
  output logic signed [31:0]         send_ch0_o,
  output logic signed [31:0]         send_ch1_o,
  output logic signed [31:0]         send_ch2_o,
  output logic signed [31:0]         send_ch3_o,
  output logic                       send_valid_o,
  output logic signed [15:0]         out_left_o,
  output logic signed [15:0]         out_right_o,
  output logic                       out_valid_o
);

  qsgm_pkg::cfg_t   cfg;
  qsgm_pkg::item_t  push_item, pop_item;
  logic             push, full, pop, empty;
  logic [3:0][31:0] in_ch, ret_ch, send_ch;
  logic [15:0]      out_left, out_right;

  assign in_ch  = {in_ch3_i, in_ch2_i, in_ch1_i, in_ch0_i};
  assign ret_ch = {ret_ch3_i, ret_ch2_i, ret_ch1_i, ret_ch0_i};

  // configuration registers
  qsgm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // front end classifies each sample: aux routing, gain, format
  qsgm_front u_front (
    .valid_i     (valid_i),
    .stall_o     (stall_o),
    .mix_index_i (mix_index_i),
    .in_ch_i     (in_ch),
    .ret_ch_i    (ret_ch),
    .cfg_i       (cfg),
    .full_i      (full),
    .push_o      (push),
    .item_o      (push_item)
  );

  // decoupling queue, lets input accept while the result side stalls
  qsgm_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .item_o  (pop_item)
  );

  // back end: arithmetic pipeline and accumulator
  qsgm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .item_i       (pop_item),
    .pop_o        (pop),
    .valid_o      (valid_o),
    .stall_i      (stall_i),
    .send_ch_o    (send_ch),
    .send_valid_o (send_valid_o),
    .out_left_o   (out_left),
    .out_right_o  (out_right),
    .out_valid_o  (out_valid_o)
  );

  assign send_ch0_o  = send_ch[0];
  assign send_ch1_o  = send_ch[1];
  assign send_ch2_o  = send_ch[2];
  assign send_ch3_o  = send_ch[3];
  assign out_left_o  = out_left;
  assign out_right_o = out_right;

`ifndef SYNTHESIS
  // a finished sample's send flag follows the mix 2 aux routing
  a_send_mix2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && out_valid_o) |-> (send_valid_o == cfg.aux2))
    else $error("send flag does not match aux2 routing on a finished sample");

  // unused send channels read as zero
  a_send_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !send_valid_o) |->
      (send_ch0_o == '0 && send_ch1_o == '0 && send_ch2_o == '0 && send_ch3_o == '0))
    else $error("send channels nonzero while send unused");

  // no sample output before mix 2
  a_out_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !out_valid_o) |-> (out_left_o == '0 && out_right_o == '0))
    else $error("output sample nonzero on a non-final mix");

  // a stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=>
      (valid_o && $stable(out_left_o) && $stable(out_right_o) &&
       $stable(send_valid_o) && $stable(out_valid_o)))
    else $error("stalled result transaction changed");
`endif

endmodule
